>>> sv/rar_pkg.sv
// types and constants shared by the rational arithmetic reduce block
// no dependencies
`default_nettype none
package rar_pkg;
	localparam int OW      = 16;
	localparam int NW      = 2 * OW;
	localparam int KW      = $clog2(NW + 1);
	localparam int CW      = $clog2(NW);
	localparam int RNW     = 33;
	localparam int RDW     = 31;
	localparam int CMDW    = 2;
	localparam int IN_BITS = CMDW + 4 * OW;
	localparam int IN_TW   = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_TW  = RNW + RDW;

	localparam logic [CMDW-1:0] CMD_ADD = 2'd0;
	localparam logic [CMDW-1:0] CMD_SUB = 2'd1;
	localparam logic [CMDW-1:0] CMD_MUL = 2'd2;
	localparam logic [CMDW-1:0] CMD_DIV = 2'd3;

	typedef struct packed {
		logic load;
		logic mul;
		logic add;
		logic gcd_step;
		logic div_init;
		logic div_step;
		logic out_load;
	} rar_cmd_t;

	typedef struct packed {
		logic dm_zero;
		logic nm_zero;
		logic gcd_done;
		logic div_last;
	} rar_stat_t;
endpackage
`default_nettype wire

>>> sv/rar_ctrl.sv
// controller state machine of the rational arithmetic reduce block
// depends on rar_pkg
`default_nettype none
module rar_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  wire               out_ready,
	input  rar_pkg::rar_stat_t stat,
	output rar_pkg::rar_cmd_t  cmd
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_ADD, ST_CHK, ST_GCD, ST_DIV, ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.mul      = (state_q == ST_MUL);
		cmd.add      = (state_q == ST_ADD);
		cmd.gcd_step = (state_q == ST_GCD) && !stat.gcd_done;
		cmd.div_init = (state_q == ST_GCD) && stat.gcd_done;
		cmd.div_step = (state_q == ST_DIV);
		cmd.out_load = (state_q == ST_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_ADD;
				ST_ADD:  state_q <= ST_CHK;
				ST_CHK: begin
					if (stat.dm_zero || stat.nm_zero)
						state_q <= ST_FIN;
					else
						state_q <= ST_GCD;
				end
				ST_GCD:  if (stat.gcd_done) state_q <= ST_DIV;
				ST_DIV:  if (stat.div_last) state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> sv/rar_dpath.sv
// datapath: products, signed sum, binary gcd, two restoring dividers, result register
// depends on rar_pkg
`default_nettype none
module rar_dpath (
	input  wire                           clk,
	input  wire                           arst_n,
	input  rar_pkg::rar_cmd_t             cmd,
	output rar_pkg::rar_stat_t            stat,
	input  wire [rar_pkg::CMDW-1:0]       command,
	input  wire signed [rar_pkg::OW-1:0]  a_num,
	input  wire signed [rar_pkg::OW-1:0]  a_den,
	input  wire signed [rar_pkg::OW-1:0]  b_num,
	input  wire signed [rar_pkg::OW-1:0]  b_den,
	output logic signed [rar_pkg::RNW-1:0] res_num,
	output logic [rar_pkg::RDW-1:0]       res_den,
	output logic                          status
);
	localparam int OW = rar_pkg::OW;
	localparam int NW = rar_pkg::NW;
	localparam int CMDW_L = rar_pkg::CMDW;

	logic [CMDW_L-1:0] cmd_q;
	logic [OW-1:0] an_q, ad_q, bn_q, bd_q;
	logic          san_q, sad_q, sbn_q, sbd_q;
	logic [NW-1:0] p1_q, p2_q, pd_q;
	logic          s1_q, s2_q, sd_q;
	logic [NW-1:0] nm_q, dm_q, gx_q, gy_q, g_q, rn_q, rd_q;
	logic          neg_q;
	logic [rar_pkg::KW-1:0] k_q;
	logic [rar_pkg::CW-1:0] cnt_q;

	function automatic logic [OW-1:0] mag(input logic [OW-1:0] v);
		mag = v[OW-1] ? (~v + 1'b1) : v;
	endfunction

	logic [OW-1:0] m1b, mdb;
	logic [NW:0]   rn_ext, rd_ext, g_ext;
	logic          ge_n, ge_d;
	logic [NW:0]   qn_ext;

	assign m1b    = (cmd_q == rar_pkg::CMD_MUL) ? bn_q : bd_q;
	assign mdb    = (cmd_q == rar_pkg::CMD_DIV) ? bn_q : bd_q;
	assign g_ext  = {1'b0, g_q};
	assign rn_ext = {rn_q, nm_q[NW-1]};
	assign rd_ext = {rd_q, dm_q[NW-1]};
	assign ge_n   = rn_ext >= g_ext;
	assign ge_d   = rd_ext >= g_ext;
	assign qn_ext = neg_q ? (~{1'b0, nm_q} + 1'b1) : {1'b0, nm_q};

	assign stat.dm_zero  = (dm_q == '0);
	assign stat.nm_zero  = (nm_q == '0);
	assign stat.gcd_done = (gx_q == '0) || (gy_q == '0);
	assign stat.div_last = (cnt_q == rar_pkg::CW'(NW - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			an_q  <= mag(a_num);
			ad_q  <= mag(a_den);
			bn_q  <= mag(b_num);
			bd_q  <= mag(b_den);
			san_q <= a_num[OW-1];
			sad_q <= a_den[OW-1];
			sbn_q <= b_num[OW-1];
			sbd_q <= b_den[OW-1];
		end
		if (cmd.mul) begin
			p1_q <= NW'(an_q) * NW'(m1b);
			p2_q <= (cmd_q == rar_pkg::CMD_ADD || cmd_q == rar_pkg::CMD_SUB) ?
				(NW'(bn_q) * NW'(ad_q)) : '0;
			pd_q <= NW'(ad_q) * NW'(mdb);
			s1_q <= san_q ^ ((cmd_q == rar_pkg::CMD_MUL) ? sbn_q : sbd_q);
			s2_q <= (cmd_q == rar_pkg::CMD_ADD || cmd_q == rar_pkg::CMD_SUB) ?
				(sbn_q ^ sad_q ^ (cmd_q == rar_pkg::CMD_SUB)) :
				(san_q ^ ((cmd_q == rar_pkg::CMD_MUL) ? sbn_q : sbd_q));
			sd_q <= sad_q ^ ((cmd_q == rar_pkg::CMD_DIV) ? sbn_q : sbd_q);
		end
		if (cmd.add) begin
			if (s1_q == s2_q) begin
				nm_q  <= p1_q + p2_q;
				gx_q  <= p1_q + p2_q;
				neg_q <= s1_q ^ sd_q;
			end else if (p1_q >= p2_q) begin
				nm_q  <= p1_q - p2_q;
				gx_q  <= p1_q - p2_q;
				neg_q <= s1_q ^ sd_q;
			end else begin
				nm_q  <= p2_q - p1_q;
				gx_q  <= p2_q - p1_q;
				neg_q <= s2_q ^ sd_q;
			end
			dm_q <= pd_q;
			gy_q <= pd_q;
			k_q  <= '0;
		end
		if (cmd.gcd_step) begin
			if (!gx_q[0] && !gy_q[0]) begin
				gx_q <= gx_q >> 1;
				gy_q <= gy_q >> 1;
				k_q  <= k_q + 1'b1;
			end else if (!gx_q[0]) begin
				gx_q <= gx_q >> 1;
			end else if (!gy_q[0]) begin
				gy_q <= gy_q >> 1;
			end else if (gx_q >= gy_q) begin
				gx_q <= gx_q - gy_q;
			end else begin
				gy_q <= gy_q - gx_q;
			end
		end
		if (cmd.div_init) begin
			g_q   <= (gx_q | gy_q) << k_q;
			rn_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			rn_q  <= ge_n ? NW'(rn_ext - g_ext) : rn_ext[NW-1:0];
			rd_q  <= ge_d ? NW'(rd_ext - g_ext) : rd_ext[NW-1:0];
			nm_q  <= {nm_q[NW-2:0], ge_n};
			dm_q  <= {dm_q[NW-2:0], ge_d};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_num <= '0;
			res_den <= '0;
			status  <= 1'b0;
		end else if (cmd.out_load) begin
			if (dm_q == '0) begin
				res_num <= '0;
				res_den <= '0;
				status  <= 1'b1;
			end else if (nm_q == '0) begin
				res_num <= '0;
				res_den <= rar_pkg::RDW'(1);
				status  <= 1'b0;
			end else begin
				res_num <= rar_pkg::RNW'($signed(qn_ext));
				res_den <= rar_pkg::RDW'(dm_q);
				status  <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

>>> sv/rational_arithmetic_reduce.sv
// top level of the rational arithmetic reduce block
// depends on rar_pkg, rar_ctrl, rar_dpath
//
// takes one request on the s_ stream: a command and two signed fractions,
// and returns their sum, difference, product or quotient reduced to lowest
// terms on the m_ stream, sign on the numerator, denominator positive.
// m_tuser high flags a zero result denominator; the data is then all zeros.
// a zero numerator gives 0/1.
// one request is worked at a time: s_tready is high only while idle.
// the products and the signed sum are formed first, then a binary gcd
// loop of one shift or subtract per cycle, then two restoring dividers
// run side by side, then the result goes into the output register;
// a zero numerator or zero denominator skips the gcd and divide loops.
// the result waits in the output register while m_tready is low, and the
// next request is taken meanwhile; it finishes and waits for the register.
// reset clears the controller and the output register; the datapath registers are not reset.
`default_nettype none
module rational_arithmetic_reduce (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         s_tvalid,
	output logic                        s_tready,
	// command[1:0], a_num[17:2], a_den[33:18], b_num[49:34], b_den[65:50], zeros
	input  wire [rar_pkg::IN_TW-1:0]    s_tdata,
	output logic                        m_tvalid,
	input  wire                         m_tready,
	// res_num[32:0], res_den[63:33]
	output logic [rar_pkg::OUT_TW-1:0]  m_tdata,
	// status[0]
	output logic                        m_tuser
);
	localparam int OW   = rar_pkg::OW;
	localparam int CMDW = rar_pkg::CMDW;

	rar_pkg::rar_cmd_t  cmd;
	rar_pkg::rar_stat_t stat;
	logic signed [rar_pkg::RNW-1:0] res_num;
	logic [rar_pkg::RDW-1:0]        res_den;
	logic                           status;

	rar_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rar_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.command (s_tdata[CMDW-1:0]),
		.a_num   (s_tdata[CMDW+OW-1:CMDW]),
		.a_den   (s_tdata[CMDW+2*OW-1:CMDW+OW]),
		.b_num   (s_tdata[CMDW+3*OW-1:CMDW+2*OW]),
		.b_den   (s_tdata[CMDW+4*OW-1:CMDW+3*OW]),
		.res_num (res_num),
		.res_den (res_den),
		.status  (status)
	);

	assign m_tdata = {res_den, res_num};
	assign m_tuser = status;
endmodule
`default_nettype wire

>>> sv/rar_checker.sv
// port-level checks of the rational arithmetic reduce block
// depends on rar_pkg and the top level rational_arithmetic_reduce
`default_nettype none
module rar_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        s_tvalid,
	input wire                        s_tready,
	input wire [rar_pkg::IN_TW-1:0]   s_tdata,
	input wire                        m_tvalid,
	input wire                        m_tready,
	input wire [rar_pkg::OUT_TW-1:0]  m_tdata,
	input wire                        m_tuser
);
	localparam int RNW = rar_pkg::RNW;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while busy");

	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("error result carries data");

	a_den: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[rar_pkg::OUT_TW-1:RNW] != '0)
		else $error("valid result with zero denominator");
endmodule

bind rational_arithmetic_reduce rar_checker u_rar_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

>>> tb/rational_arithmetic_reduce_test.sv
// testbench for rational_arithmetic_reduce: drives fraction requests on the s_ stream
// and checks each reduced result on the m_ stream against an in-bench predictor
// depends on rar_pkg and rational_arithmetic_reduce
`timescale 1ns / 100ps
`default_nettype none
module rational_arithmetic_reduce_test;
	import rar_pkg::*;

	typedef struct packed {
		logic [RNW-1:0] num;
		logic [RDW-1:0] den;
		logic           status;
	} fraction_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_TW-1:0]  s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_TW-1:0] m_tdata;
	logic              m_tuser;

	fraction_t  pending_q[$];
	int         error_count = 0;
	bit         quiet = 1'b0;

	rational_arithmetic_reduce i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic report(input string what, input longint got, input longint want);
		error_count++;
		$display("mismatch %s: got %0h want %0h", what, got, want);
	endtask

	function automatic logic [63:0] magnitude(input logic [OW-1:0] v);
		return v[OW-1] ? 64'(-$signed({1'b1, v}) ) & 64'hffff_ffff : 64'(v);
	endfunction

	function automatic fraction_t reduce_fraction(input logic [CMDW-1:0] op,
			input logic [OW-1:0] an_r, ad_r, bn_r, bd_r);
		logic [63:0] an, ad, bn, bd, t1, t2, nm, dm, x, y;
		logic        san, sad, sbn, sbd, s1, s2, sn, sd;
		fraction_t   r;
		an = magnitude(an_r); ad = magnitude(ad_r);
		bn = magnitude(bn_r); bd = magnitude(bd_r);
		san = an_r[OW-1]; sad = ad_r[OW-1]; sbn = bn_r[OW-1]; sbd = bd_r[OW-1];
		case (op)
			CMD_ADD, CMD_SUB: begin
				t1 = an * bd; t2 = bn * ad;
				s1 = san ^ sbd; s2 = sbn ^ sad;
				if (op == CMD_SUB) s2 = !s2;
				if (s1 == s2) begin
					nm = t1 + t2; sn = s1;
				end else if (t1 >= t2) begin
					nm = t1 - t2; sn = s1;
				end else begin
					nm = t2 - t1; sn = s2;
				end
				dm = ad * bd; sd = sad ^ sbd;
			end
			CMD_MUL: begin
				nm = an * bn; sn = san ^ sbn; dm = ad * bd; sd = sad ^ sbd;
			end
			default: begin
				nm = an * bd; sn = san ^ sbd; dm = ad * bn; sd = sad ^ sbn;
			end
		endcase
		r = '0;
		if (dm == 0) begin
			r.status = 1'b1;
		end else if (nm == 0) begin
			r.den = RDW'(1);
		end else begin
			x = nm; y = dm;
			while (x != 0 && y != 0) begin
				if (x > y) x = x % y;
				else y = y % x;
			end
			nm = nm / (x + y); dm = dm / (x + y);
			r.num = (sn ^ sd) ? RNW'(-nm) : RNW'(nm);
			r.den = RDW'(dm);
		end
		return r;
	endfunction

	function automatic logic [15:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'(int'($urandom_range(0, 8)) - 4);
			4, 5: return 16'(int'($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_request(input logic [CMDW-1:0] op,
			input logic [OW-1:0] an, ad, bn, bd);
		while (!quiet && $urandom_range(0, 99) < 36) @(posedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= IN_TW'({bd, bn, ad, an, op});
		pending_q.push_back(reduce_fraction(op, an, ad, bn, bd));
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		fraction_t want;
		m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 36);
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_q.size() == 0) begin
				report("unexpected result", longint'(m_tdata), 0);
			end else begin
				want = pending_q.pop_front();
				if (m_tdata[RNW-1:0] !== want.num)
					report("res_num", longint'(m_tdata[RNW-1:0]), longint'(want.num));
				if (m_tdata[OUT_TW-1:RNW] !== want.den)
					report("res_den", longint'(m_tdata[OUT_TW-1:RNW]), longint'(want.den));
				if (m_tuser !== want.status)
					report("status", longint'(m_tuser), longint'(want.status));
			end
		end
	end

	task automatic test_directed();
		for (int op = 0; op < 4; op++) begin
			send_request(2'(op), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
			send_request(2'(op), 16'h7fff, 16'h8000, 16'h8001, 16'h7fff);
			send_request(2'(op), 16'h0000, 16'h0003, 16'h0000, 16'hfffb);
			send_request(2'(op), 16'h0001, 16'h0000, 16'h0002, 16'h0003);
			send_request(2'(op), 16'hffff, 16'h0006, 16'h0004, 16'hfff8);
		end
		send_request(CMD_DIV, 16'h0005, 16'h0007, 16'h0000, 16'h0009);
		send_request(CMD_SUB, 16'h0003, 16'h0004, 16'h0003, 16'h0004);
		send_request(CMD_ADD, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
	endtask

	task automatic wait_drained();
		while (pending_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++)
			send_request(2'($urandom), pick_operand(), pick_operand(),
				pick_operand(), pick_operand());
	endtask

	task automatic test_no_idle();
		quiet = 1'b1;
		test_random(60);
		wait_drained();
		quiet = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_drained();
		test_random(200);
		test_no_idle();
		test_random(240);
		wait_drained();
		repeat (300) @(posedge clk);
		if (error_count == 0 && pending_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
